// ===== hdl/battery_monitor_filter_top_macros.svh =====
// Assertion macros used by the battery monitor filter checker.
`ifndef BATTERY_MONITOR_FILTER_TOP_MACROS_SVH
`define BATTERY_MONITOR_FILTER_TOP_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define BMF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("battery monitor filter check failed");

// Concurrent assertion that also holds across reset.
`define BMF_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("battery monitor filter reset check failed");

`endif

// ===== hdl/bmf_pkg.sv =====
// Package with widths, gains and register indexes of the battery monitor filter.
package bmf_pkg;

  localparam int WINDOW_LENGTH = 5;

  localparam int CODE_W  = 12;
  localparam int POS_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int SUM_W   = CODE_W + ((WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 0);

  localparam int VQ_W    = 13;
  localparam int CQ_W    = 15;
  localparam int CQX_W   = 17;
  localparam int CLIM_W  = 14;
  localparam int COUNT_W = 8;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_INDEX_W = 3;

  localparam int GAIN_SHIFT = 16;
  localparam int VGAIN   = 74800 / WINDOW_LENGTH;
  localparam int CGAIN   = 242090 / WINDOW_LENGTH;
  localparam int VGAIN_W = 17;
  localparam int CGAIN_W = 18;
  localparam int VPROD_W = SUM_W + VGAIN_W;
  localparam int CPROD_W = SUM_W + CGAIN_W;
  localparam int CURRENT_OFFSET = 1280;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOW_CHECK_ENABLE  = 3'd0,
    REG_LOW_VOLTAGE_LIMIT = 3'd1,
    REG_CURRENT_LIMIT     = 3'd2,
    REG_LOW_RUN_LIMIT     = 3'd3,
    REG_REPORT_EVERY      = 3'd4
  } reg_index_t;

endpackage

// ===== hdl/bmf_sample_if.sv =====
// Input channel of the battery monitor filter: one sensor word per handshake.
interface bmf_sample_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::CODE_W-1:0] voltage_code;
  logic [bmf_pkg::CODE_W-1:0] current_code;
  logic                       motor_stopped;

  modport source (output valid, output voltage_code, output current_code,
                  output motor_stopped, input ready);
  modport sink   (input valid, input voltage_code, input current_code,
                  input motor_stopped, output ready);
endinterface

// ===== hdl/bmf_result_if.sv =====
// Output channel of the battery monitor filter: one filtered word per handshake.
interface bmf_result_if;
  logic                            valid;
  logic                            ready;
  logic [bmf_pkg::VQ_W-1:0]        voltage_q10;
  logic signed [bmf_pkg::CQ_W-1:0] current_q10;
  logic                            over_current;
  logic                            battery_low;
  logic                            report_now;

  modport source (output valid, output voltage_q10, output current_q10,
                  output over_current, output battery_low, output report_now,
                  input ready);
  modport sink   (input valid, input voltage_q10, input current_q10,
                  input over_current, input battery_low, input report_now,
                  output ready);
endinterface

// ===== hdl/bmf_window.sv =====
// Moving window of converter codes with a running sum for one channel.
module bmf_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [bmf_pkg::POS_W-1:0]   pos,
  input  logic [bmf_pkg::CODE_W-1:0]  code,
  output logic [bmf_pkg::SUM_W-1:0]   sum
);
  import bmf_pkg::*;

  logic [CODE_W-1:0] win [WINDOW_LENGTH];

  // The running sum drops the sample being overwritten and adds the new one,
  // which always equals the total of the window contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win[i] <= '0;
      end
      sum <= '0;
    end else if (load) begin
      win[pos] <= code;
      sum      <= sum - SUM_W'(win[pos]) + SUM_W'(code);
    end
  end

endmodule

// ===== hdl/battery_monitor_filter_top.sv =====
// Top level of the battery monitor filter: windows, scaling, checks and report strobe.
//
//   channel  direction  contents
//   sample   in         voltage_code, current_code, motor_stopped
//   result   out        voltage_q10, current_q10, over_current, battery_low, report_now
//   config   in         write_enable, reg_index, write_data
//
// One word is accepted per cycle while no stall backs up the stages; each result passes
// through the window stage, the registered gain multipliers and the check stage.
// Synchronous reset clears the windows, sums, run count, report phase and latch,
// and restores the register defaults; no clearing pass is needed.
// A stalled result holds in the output register while the stages behind it keep
// filling; each stage moves when the one after it is empty or moving.
module battery_monitor_filter_top (
  input  logic                            clk,
  input  logic                            rst,
  bmf_sample_if.sink                      sample,
  bmf_result_if.source                    result,
  input  logic                            write_enable,
  input  logic [bmf_pkg::CFG_INDEX_W-1:0] reg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]  write_data
);
  import bmf_pkg::*;

  // Configuration registers.
  logic              low_check_enable;
  logic [VQ_W-1:0]   low_voltage_limit;
  logic [CLIM_W-1:0] current_limit;
  logic [COUNT_W-1:0] low_run_limit;
  logic [COUNT_W-1:0] report_every;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_check_enable  <= 1'b1;
      low_voltage_limit <= VQ_W'(3686);
      current_limit     <= CLIM_W'(10240);
      low_run_limit     <= COUNT_W'(10);
      report_every      <= COUNT_W'(5);
    end else if (write_enable) begin
      unique case (reg_index)
        REG_LOW_CHECK_ENABLE:  low_check_enable  <= write_data[0];
        REG_LOW_VOLTAGE_LIMIT: low_voltage_limit <= write_data[VQ_W-1:0];
        REG_CURRENT_LIMIT:     current_limit     <= write_data[CLIM_W-1:0];
        REG_LOW_RUN_LIMIT:     low_run_limit     <= write_data[COUNT_W-1:0];
        REG_REPORT_EVERY:      report_every      <= write_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake.
  logic v1, v2, v3;
  logic adv1, adv2, adv3;
  logic load;

  assign adv3 = !v3 || result.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign sample.ready = adv1;
  assign load = sample.valid && adv1;

  // Stage 1: window update and running sums.
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [SUM_W-1:0] vsum1, csum1;
  logic             stopped1;

  assign pos_next = (pos == POS_W'(WINDOW_LENGTH - 1)) ? '0 : pos + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      v1  <= 1'b0;
    end else begin
      if (load) begin
        pos <= pos_next;
      end
      if (adv1) begin
        v1 <= sample.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stopped1 <= sample.motor_stopped;
    end
  end

  bmf_window u_voltage_window (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .pos  (pos),
    .code (sample.voltage_code),
    .sum  (vsum1)
  );

  bmf_window u_current_window (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .pos  (pos),
    .code (sample.current_code),
    .sum  (csum1)
  );

  // Stage 2: gain multiplies and offset.
  logic [VPROD_W-1:0]     vprod;
  logic [CPROD_W-1:0]     cprod;
  logic [VQ_W-1:0]        vq2;
  logic signed [CQX_W-1:0] cq2;
  logic                   stopped2;

  assign vprod = VPROD_W'(vsum1) * VPROD_W'(VGAIN);
  assign cprod = CPROD_W'(csum1) * CPROD_W'(CGAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      vq2      <= vprod[GAIN_SHIFT +: VQ_W];
      cq2      <= $signed({2'b00, cprod[GAIN_SHIFT +: CQ_W]}) - CQX_W'(CURRENT_OFFSET);
      stopped2 <= stopped1;
    end
  end

  // Stage 3: limit checks, low run, report phase and output register.
  logic [COUNT_W-1:0] low_run, low_run_next;
  logic [COUNT_W-1:0] phase, phase_next;
  logic               latched, latched_next;
  logic               over, report;
  logic               low_hit;
  logic [COUNT_W-1:0] run_inc;
  logic [COUNT_W-1:0] period;
  logic [COUNT_W:0]   phase_inc;
  logic               take3;

  assign take3 = adv3 && v2;

  always_comb begin
    over      = (cq2 >= $signed({3'b000, current_limit}));
    low_hit   = stopped2 && (vq2 < low_voltage_limit);
    run_inc   = (low_run == '1) ? low_run : low_run + COUNT_W'(1);
    period    = (report_every == '0) ? COUNT_W'(1) : report_every;
    phase_inc = {1'b0, phase} + (COUNT_W+1)'(1);

    low_run_next = low_run;
    latched_next = latched;
    phase_next   = phase;
    report       = 1'b0;

    if (!over) begin
      if (low_check_enable && low_hit) begin
        low_run_next = run_inc;
        if (run_inc > low_run_limit) begin
          latched_next = 1'b1;
        end
      end else begin
        low_run_next = '0;
      end
      report = (phase == '0);
      // A phase left at or past a shortened period wraps to zero here.
      phase_next = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3      <= 1'b0;
      low_run <= '0;
      phase   <= '0;
      latched <= 1'b0;
    end else begin
      if (adv3) begin
        v3 <= v2;
      end
      if (take3) begin
        low_run <= low_run_next;
        phase   <= phase_next;
        latched <= latched_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take3) begin
      result.voltage_q10  <= vq2;
      result.current_q10  <= cq2[CQ_W-1:0];
      result.over_current <= over;
      result.battery_low  <= latched_next;
      result.report_now   <= report;
    end
  end

  assign result.valid = v3;

endmodule

// ===== hdl/bmf_checker.sv =====
// Port-level checker for the battery monitor filter and its bind to the top level.
`include "battery_monitor_filter_top_macros.svh"

module bmf_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic over_current,
  input logic battery_low,
  input logic report_now
);

  // Remembers that a delivered word already showed the low battery latch.
  logic seen_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_low <= 1'b0;
    end else if (out_valid && out_ready && battery_low) begin
      seen_low <= 1'b1;
    end
  end

  `BMF_ASSERT(a_hold_valid, clk, rst, out_valid && !out_ready |=> out_valid)
  `BMF_ASSERT(a_over_no_report, clk, rst, out_valid && over_current |-> !report_now)
  `BMF_ASSERT(a_latch_sticky, clk, rst, out_valid && seen_low |-> battery_low)
  `BMF_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> in_ready)
  `BMF_ASSERT_RST(a_reset_empties, clk, rst |=> !out_valid)

endmodule

bind battery_monitor_filter_top bmf_checker u_bmf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (sample.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .over_current (result.over_current),
  .battery_low  (result.battery_low),
  .report_now   (result.report_now)
);
